// File: rtl/ffm_pkg.sv
// ----------------------------------------------------------------------------
// ffm_pkg
// Shared codes and controller/datapath interface types for the feed merge unit.
// ----------------------------------------------------------------------------
package ffm_pkg;

  localparam logic [1:0] CMD_POST     = 2'd0;
  localparam logic [1:0] CMD_FEED     = 2'd1;
  localparam logic [1:0] CMD_FOLLOW   = 2'd2;
  localparam logic [1:0] CMD_UNFOLLOW = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;

  localparam int STAMP_W = 32;
  localparam int POST_W  = 16;

  typedef struct packed {
    logic latch;
    logic dec;
    logic cnt_rd;
    logic ent_rd;
    logic next_user;
    logic emit;
  } ffm_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       ent_more;
    logic       last_user;
    logic       out_done;
    logic       out_last;
  } ffm_sts_t;

endpackage

// File: rtl/follow_feed_merge_unit.sv
// ----------------------------------------------------------------------------
// follow_feed_merge_unit
// Follow graph with per-user recent posts and a newest-first merged feed.
// ----------------------------------------------------------------------------
// Input channel in_*: one command per item (post, feed, follow, unfollow).
// Result channel out_*: post gives one item; feed gives 1..FEED_LEN post ids,
// newest first, or one item with status empty; follow/unfollow give none.
// tlast marks the final result of a command.
// One command is handled at a time; in_tready is high only when idle.
// Follow/unfollow: decode and row write. Post: decode, ring write, then result handshake.
// Feed: a scan over all users in the post ring memory, reading the entries
// of the requester and followed users (one entry read per cycle), then
// the results are emitted one at a time, each waiting for its handshake.
// Reset clears follow rows and ring counts through valid bits at once and
// zeroes the stamp counter; no clearing pass is needed.
// A stalled receiver holds the result in the output register and the block
// waits; no result is dropped.
// ----------------------------------------------------------------------------
module follow_feed_merge_unit #(
  parameter int NUM_USERS = 64,
  parameter int FEED_LEN  = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // cmd[1:0], user_id[7:2], post_id[23:8], target_user[29:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // status[1:0], feed_post_id[17:2]
  output logic        out_tlast
);
  import ffm_pkg::*;

  ffm_cmd_t cmd;
  ffm_sts_t sts;

  ffm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffm_dp #(
    .NUM_USERS (NUM_USERS),
    .FEED_LEN  (FEED_LEN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: rtl/ffm_ctrl.sv
// ----------------------------------------------------------------------------
// ffm_ctrl
// Sequencer: decodes each item, walks the users during a feed scan and
// paces result delivery.
// ----------------------------------------------------------------------------
module ffm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ffm_pkg::ffm_sts_t sts,
  output ffm_pkg::ffm_cmd_t cmd
);
  import ffm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_CNT   = 3'd2;
  localparam logic [2:0] S_ENT   = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_OUTW  = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.dec = 1'b1;
        case (sts.op)
          CMD_POST: state_nxt = S_OUTW;
          CMD_FEED: state_nxt = S_CNT;
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_CNT: begin
        cmd.cnt_rd = 1'b1;
        state_nxt  = S_ENT;
      end
      S_ENT: begin
        if (sts.ent_more) begin
          cmd.ent_rd = 1'b1;
        end else if (sts.last_user) begin
          state_nxt = S_FLUSH;
        end else begin
          cmd.next_user = 1'b1;
          state_nxt     = S_CNT;
        end
      end
      S_FLUSH: state_nxt = S_EMIT;
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_OUTW;
      end
      S_OUTW: begin
        if (sts.out_done) begin
          state_nxt = sts.out_last ? S_IDLE : S_EMIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_emit_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> $past(state_r) == S_OUTW || $past(state_r) == S_FLUSH)
    else $error("emit outside result sequence");
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ent_rd |-> !in_tready && !cmd.next_user)
    else $error("entry read while idle");
  a_dec_after_latch: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> cmd.dec)
    else $error("decode did not follow accept");

endmodule

// File: rtl/ffm_dp.sv
// ----------------------------------------------------------------------------
// ffm_dp
// Datapath: follow rows, per-user post rings, stamp counter, top-N list
// with parallel sorted insert, and the result register.
// ----------------------------------------------------------------------------
module ffm_dp #(
  parameter int NUM_USERS = 64,
  parameter int FEED_LEN  = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [31:0]       in_tdata,
  input  ffm_pkg::ffm_cmd_t cmd,
  output ffm_pkg::ffm_sts_t sts,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,
  output logic              out_tlast
);
  import ffm_pkg::*;

  localparam int UW = $clog2(NUM_USERS);
  localparam int CW = $clog2(FEED_LEN + 1);
  localparam int HW = (FEED_LEN > 1) ? $clog2(FEED_LEN) : 1;
  localparam int AW = $clog2(NUM_USERS * FEED_LEN);

  function automatic logic [UW-1:0] user_mod(input logic [5:0] x);
    logic [16:0] r;
    r = {11'd0, x};
    for (int k = 5; k >= 0; k--) begin
      if (r >= (17'(NUM_USERS) << k)) r = r - (17'(NUM_USERS) << k);
    end
    return r[UW-1:0];
  endfunction

  // input fields
  logic [1:0]        in_op;
  logic [UW-1:0]     in_u, in_t;
  logic [POST_W-1:0] in_pid;
  assign in_op  = in_tdata[1:0];
  assign in_u   = user_mod(in_tdata[7:2]);
  assign in_pid = in_tdata[23:8];
  assign in_t   = user_mod(in_tdata[29:24]);

  logic [1:0]         op_r;
  logic [UW-1:0]      u_r, t_r, v_r;
  logic [POST_W-1:0]  pid_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [AW-1:0]      base_r;
  logic [CW-1:0]      j_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_op;
      u_r   <= in_u;
      t_r   <= in_t;
      pid_r <= in_pid;
    end
  end

  // follow rows
  logic [NUM_USERS-1:0] row_mem [NUM_USERS];
  logic [NUM_USERS-1:0] rv_r, row_q, row_eff, row_wd, sel_r;
  logic                 rvalid_q, row_we;

  assign row_eff = rvalid_q ? row_q : '0;
  assign row_we  = cmd.dec && (op_r == CMD_FOLLOW || op_r == CMD_UNFOLLOW);
  always_comb begin
    row_wd      = row_eff;
    row_wd[t_r] = (op_r == CMD_FOLLOW);
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[u_r] <= row_wd;
    if (cmd.latch) row_q <= row_mem[in_u];
  end

  // per-user ring count and head
  logic [CW-1:0] cnt_mem [NUM_USERS];
  logic [HW-1:0] head_mem [NUM_USERS];
  logic [NUM_USERS-1:0] cv_r;
  logic [CW-1:0] cnt_q, cnt_eff, cnt_u, cnt_new;
  logic [HW-1:0] head_q, head_u, head_new;
  logic          cvalid_q, elig_q, post_we, full;
  logic [UW-1:0] cnt_ra;

  assign full     = (stamp_r == '1);
  assign post_we  = cmd.dec && (op_r == CMD_POST) && !full;
  assign cnt_ra   = cmd.latch ? in_u : v_r;
  assign cnt_u    = cvalid_q ? cnt_q : '0;
  assign head_u   = cvalid_q ? head_q : '0;
  assign cnt_eff  = (cvalid_q && elig_q) ? cnt_q : '0;
  assign head_new = (head_u == HW'(FEED_LEN - 1)) ? '0 : head_u + 1'b1;
  assign cnt_new  = (cnt_u == CW'(FEED_LEN)) ? cnt_u : cnt_u + 1'b1;

  always_ff @(posedge clk) begin
    if (post_we) begin
      cnt_mem[u_r]  <= cnt_new;
      head_mem[u_r] <= head_new;
    end
    if (cmd.latch || cmd.cnt_rd) begin
      cnt_q  <= cnt_mem[cnt_ra];
      head_q <= head_mem[cnt_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r     <= '0;
      cv_r     <= '0;
      rvalid_q <= 1'b0;
      cvalid_q <= 1'b0;
      elig_q   <= 1'b0;
      stamp_r  <= '0;
    end else begin
      if (row_we) rv_r[u_r] <= 1'b1;
      if (post_we) cv_r[u_r] <= 1'b1;
      if (cmd.latch) rvalid_q <= rv_r[in_u];
      if (cmd.latch || cmd.cnt_rd) cvalid_q <= cv_r[cnt_ra];
      if (cmd.cnt_rd) elig_q <= sel_r[v_r];
      if (post_we) stamp_r <= stamp_r + 1'b1;
    end
  end

  // post rings
  logic [STAMP_W-1:0] stamp_mem [NUM_USERS*FEED_LEN];
  logic [POST_W-1:0]  post_mem [NUM_USERS*FEED_LEN];
  logic [STAMP_W-1:0] rs_q;
  logic [POST_W-1:0]  rp_q;
  logic [AW-1:0]      wa, ra;
  logic               pend_r;

  assign wa = AW'(u_r) * AW'(FEED_LEN) + AW'(head_u);
  assign ra = base_r + AW'(j_r);

  always_ff @(posedge clk) begin
    if (post_we) begin
      stamp_mem[wa] <= stamp_r;
      post_mem[wa]  <= pid_r;
    end
    if (cmd.ent_rd) begin
      rs_q <= stamp_mem[ra];
      rp_q <= post_mem[ra];
    end
  end

  // scan position
  logic feed_init;
  assign feed_init = cmd.dec && (op_r == CMD_FEED);

  always_ff @(posedge clk) begin
    if (feed_init) begin
      sel_r  <= row_eff | (NUM_USERS'(1) << u_r);
      v_r    <= '0;
      base_r <= '0;
      j_r    <= '0;
    end else if (cmd.next_user) begin
      v_r    <= v_r + 1'b1;
      base_r <= base_r + AW'(FEED_LEN);
      j_r    <= '0;
    end else if (cmd.ent_rd) begin
      j_r <= j_r + 1'b1;
    end
  end

  // top-N list, newest first
  logic [STAMP_W-1:0] ls_r [FEED_LEN];
  logic [POST_W-1:0]  lp_r [FEED_LEN];
  logic [FEED_LEN-1:0] lv_r, lv_ins, lv_sh, gt;
  logic [STAMP_W-1:0] ls_ins [FEED_LEN];
  logic [POST_W-1:0]  lp_ins [FEED_LEN];

  assign lv_sh = lv_r >> 1;

  always_comb begin
    for (int i = 0; i < FEED_LEN; i++) begin
      gt[i] = !lv_r[i] || (rs_q > ls_r[i]);
    end
    for (int i = 0; i < FEED_LEN; i++) begin
      if (gt[i] && (i == 0 || !gt[(i == 0) ? 0 : i - 1])) begin
        ls_ins[i] = rs_q;
        lp_ins[i] = rp_q;
        lv_ins[i] = 1'b1;
      end else if (gt[i]) begin
        ls_ins[i] = ls_r[(i == 0) ? 0 : i - 1];
        lp_ins[i] = lp_r[(i == 0) ? 0 : i - 1];
        lv_ins[i] = lv_r[(i == 0) ? 0 : i - 1];
      end else begin
        ls_ins[i] = ls_r[i];
        lp_ins[i] = lp_r[i];
        lv_ins[i] = lv_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      for (int i = 0; i < FEED_LEN - 1; i++) begin
        ls_r[i] <= ls_r[i + 1];
        lp_r[i] <= lp_r[i + 1];
      end
    end else if (pend_r) begin
      for (int i = 0; i < FEED_LEN; i++) begin
        ls_r[i] <= ls_ins[i];
        lp_r[i] <= lp_ins[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r   <= '0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.ent_rd;
      if (feed_init) lv_r <= '0;
      else if (cmd.emit) lv_r <= lv_sh;
      else if (pend_r) lv_r <= lv_ins;
    end
  end

  // result register
  logic              ov_r, ol_r;
  logic [1:0]        ost_r;
  logic [POST_W-1:0] oid_r;
  logic              post_dec;

  assign post_dec = cmd.dec && (op_r == CMD_POST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (post_dec || cmd.emit) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post_dec) begin
      ost_r <= full ? ST_REJECTED : ST_OK;
      oid_r <= '0;
      ol_r  <= 1'b1;
    end else if (cmd.emit) begin
      ost_r <= lv_r[0] ? ST_OK : ST_EMPTY;
      oid_r <= lv_r[0] ? lp_r[0] : '0;
      ol_r  <= !lv_r[0] || !lv_sh[0];
    end
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = ol_r;
  assign out_tdata  = {6'd0, oid_r, ost_r};

  assign sts.op        = op_r;
  assign sts.ent_more  = (j_r < cnt_eff);
  assign sts.last_user = (v_r == UW'(NUM_USERS - 1));
  assign sts.out_done  = ov_r && out_tready;
  assign sts.out_last  = ol_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (post_dec || cmd.emit) |-> !ov_r)
    else $error("result register overwritten");
  a_list_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (lv_sh & ~lv_r) == '0)
    else $error("top list has a hole");
  a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && stamp_r != $past(stamp_r)) |-> stamp_r == $past(stamp_r) + 1'b1)
    else $error("stamp counter jumped");

endmodule
